### rtl/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Shared types, constants and the arctangent table for the DPSK fine-AFC
// demodulator.
// ----------------------------------------------------------------------------
package dfa_pkg;

  localparam int SampleBitsDef  = 16;
  localparam int CordicStepsDef = 16;
  localparam int DivSteps       = 17;   // quotient bits, enough to saturate to 16 bits
  localparam int WorkW          = 44;   // CORDIC working width, Q29 with headroom
  localparam int StepW          = 5;    // covers up to 24 micro-rotations
  localparam int AvgW           = 32;
  localparam int LeakShift      = 5;
  localparam int RoundShift     = 8;    // Q29 to Q21
  localparam int MulSplit       = 18;   // low slice width of the gain multiply
  localparam logic [29:0] InvGain    = 30'd652032874;
  localparam logic [31:0] EighthTurn = 32'h2000_0000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_VEC_STEP,
    OP_ROT_STEP,
    OP_MUL_XL,
    OP_MUL_XH,
    OP_MUL_YL,
    OP_MUL_YH,
    OP_ROT_MAG,
    OP_AVG,
    OP_VEC_AVG,
    OP_ROT_D,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RESULT,
    OP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [StepW-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic mag_nz;
    logic avg_nz;
    logic level_nz;
    logic qpsk;
  } dp_status_t;

  // Binary-angle arctangent of 2^-i, a full turn being 2^32.
  function automatic logic [31:0] atan_val(input logic [StepW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/dfa_ctrl.sv
// ----------------------------------------------------------------------------
// dfa_ctrl
// Sequencer: steps the shared CORDIC, gain multiplier and divider through the
// work of one symbol and hands the result to the output register.
// ----------------------------------------------------------------------------
module dfa_ctrl #(
  parameter int CordicSteps = dfa_pkg::CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  input  dfa_pkg::dp_status_t status_i,
  output dfa_pkg::dp_cmd_t    cmd_o
);
  import dfa_pkg::*;

  localparam int MaxSteps = (CordicSteps > DivSteps) ? CordicSteps : DivSteps;
  localparam int CntW     = $clog2(MaxSteps);

  typedef enum logic [3:0] {
    S_IDLE, S_VEC, S_ROT, S_MXL, S_MXH, S_MYL, S_MYH, S_MAGCHK,
    S_AVG, S_AVGCHK, S_TURN, S_DIVI, S_DIV, S_RES, S_OUT
  } state_e;

  typedef enum logic [1:0] {PH_D, PH_MAG, PH_AVG, PH_FIN} phase_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  dp_op_e          op;
  logic            cordic_last, div_last;

  assign cordic_last = (cnt_q == CntW'(CordicSteps - 1));
  assign div_last    = (cnt_q == CntW'(DivSteps - 1));

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          phase_d = PH_D;
          cnt_d   = '0;
          state_d = S_VEC;
        end
      end
      S_VEC: begin
        op    = OP_VEC_STEP;
        cnt_d = cnt_q + 1'b1;
        if (cordic_last) begin
          cnt_d   = '0;
          state_d = (phase_q == PH_D) ? S_MXL : S_TURN;
        end
      end
      S_ROT: begin
        op    = OP_ROT_STEP;
        cnt_d = cnt_q + 1'b1;
        if (cordic_last) begin
          cnt_d   = '0;
          state_d = S_MXL;
        end
      end
      S_MXL: begin
        op      = OP_MUL_XL;
        state_d = S_MXH;
      end
      S_MXH: begin
        op      = OP_MUL_XH;
        state_d = (phase_q == PH_D) ? S_MAGCHK : S_MYL;
      end
      S_MYL: begin
        op      = OP_MUL_YL;
        state_d = S_MYH;
      end
      S_MYH: begin
        op = OP_MUL_YH;
        if (phase_q == PH_MAG) begin
          state_d = S_AVG;
        end else begin
          state_d = (status_i.qpsk && status_i.level_nz) ? S_DIVI : S_RES;
        end
      end
      S_MAGCHK: begin
        // A zero magnitude leaves every average untouched.
        if (status_i.mag_nz) begin
          op      = OP_ROT_MAG;
          phase_d = PH_MAG;
          state_d = S_ROT;
        end else begin
          state_d = S_AVGCHK;
        end
      end
      S_AVG: begin
        op      = OP_AVG;
        state_d = S_AVGCHK;
      end
      S_AVGCHK: begin
        if (status_i.avg_nz) begin
          op      = OP_VEC_AVG;
          phase_d = PH_AVG;
          state_d = S_VEC;
        end else begin
          op      = OP_ROT_D;
          phase_d = PH_FIN;
          state_d = S_ROT;
        end
      end
      S_TURN: begin
        op      = OP_ROT_D;
        phase_d = PH_FIN;
        state_d = S_ROT;
      end
      S_DIVI: begin
        op      = OP_DIV_INIT;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        op    = OP_DIV_STEP;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          cnt_d   = '0;
          state_d = S_RES;
        end
      end
      S_RES: begin
        op      = OP_RESULT;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          op      = OP_OUT_LOAD;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_D;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op   = op;
  assign cmd_o.step = StepW'(cnt_q);

endmodule

### rtl/dfa_datapath.sv
// ----------------------------------------------------------------------------
// dfa_datapath
// Shared CORDIC, two-slice gain multiplier, leaky averages, two-lane restoring
// divider and result registers.
// ----------------------------------------------------------------------------
module dfa_datapath #(
  parameter int SampleBits = dfa_pkg::SampleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfa_pkg::dp_cmd_t    cmd_i,
  input  logic                qpsk_i,
  input  logic [15:0]         diff_real_i,
  input  logic [15:0]         diff_imag_i,
  input  logic [31:0]         sample_tag_i,
  output dfa_pkg::dp_status_t status_o,
  output logic                hard_bit_o,
  output logic [15:0]         soft_first_o,
  output logic [15:0]         soft_second_o,
  output logic [31:0]         tag_out_o
);
  import dfa_pkg::*;

  localparam int HiW   = WorkW - MulSplit;
  localparam int PhW   = HiW + 31;
  localparam int SumW  = WorkW + 31;
  localparam int PloW  = MulSplit + 30;
  localparam int DivW  = 48;

  logic signed [WorkW-1:0] x_q, y_q, ux_q, uy_q;
  logic signed [33:0]      z_q;
  logic signed [31:0]      x0_q, y0_q, ar_q, ai_q;
  logic [31:0]             lv_q, mag21_q, tag_q;
  logic [PloW-1:0]         plo_q;
  logic [DivW-1:0]         r_q [2];
  logic [DivW-1:0]         d_q;
  logic [DivSteps-1:0]     qt_q [2];
  logic                    neg_q [2];
  logic                    ovf_q [2];
  logic                    hard_q;
  logic [15:0]             soft_q [2];

  function automatic logic signed [WorkW-1:0] to_work(input logic [15:0] raw);
    logic [SampleBits-1:0] r;
    r = SampleBits'(raw);
    return WorkW'($signed(r)) <<< (32 - SampleBits);
  endfunction

  function automatic logic signed [WorkW-1:0] round21(input logic signed [WorkW-1:0] v);
    return (v + WorkW'(128)) >>> RoundShift;
  endfunction

  // Combinational helpers for the CORDIC and the multiplier.
  logic signed [WorkW-1:0] xs, ys, vx_in, vy_in, rx_in, ry_in;
  logic signed [WorkW-1:0] vx_i, vy_i, rx_i, ry_i;
  logic signed [33:0]      vz_i, rz_i, atn, zs;
  logic [31:0]             rot_angle, turn;
  logic signed [31:0]      psi, psi_sh;
  logic signed [WorkW-1:0] src, mul_res, mag21, rx21, ry21;
  logic signed [PhW-1:0]   ph;
  logic signed [SumW-1:0]  msum;
  logic signed [WorkW-1:0] ar_w, ai_w;
  logic signed [33:0]      lv_w, lv_n;
  logic                    sh2;

  assign sh2 = qpsk_i;
  assign xs  = x_q >>> cmd_i.step;
  assign ys  = y_q >>> cmd_i.step;
  assign atn = $signed({2'b00, atan_val(cmd_i.step)});

  // Vectoring start: fold the left half plane over.
  assign vx_in = (cmd_i.op == OP_LOAD) ? to_work(diff_real_i) : (WorkW'(ar_q) <<< 8);
  assign vy_in = (cmd_i.op == OP_LOAD) ? to_work(diff_imag_i) : (WorkW'(ai_q) <<< 8);
  always_comb begin
    if (vx_in < 0) begin
      vx_i = -vx_in;
      vy_i = -vy_in;
      vz_i = 34'sh0_8000_0000;
    end else begin
      vx_i = vx_in;
      vy_i = vy_in;
      vz_i = '0;
    end
  end

  // Rotation start: angles beyond a quarter turn are taken as a half turn plus the rest.
  assign psi    = $signed(z_q[31:0]);
  assign psi_sh = sh2 ? (psi >>> 2) : (psi >>> 1);
  assign turn   = (status_o.avg_nz ? 32'(-psi_sh) : 32'd0) + (qpsk_i ? EighthTurn : 32'd0);
  assign rot_angle = (cmd_i.op == OP_ROT_MAG) ? (sh2 ? z_q[31:0] << 2 : z_q[31:0] << 1)
                                              : turn;
  assign rx_in = (cmd_i.op == OP_ROT_MAG) ? ux_q : WorkW'(x0_q);
  assign ry_in = (cmd_i.op == OP_ROT_MAG) ? '0   : WorkW'(y0_q);
  assign zs    = $signed({{2{rot_angle[31]}}, rot_angle});
  always_comb begin
    if (zs > 34'sd1073741824 || zs < -34'sd1073741824) begin
      rx_i = -rx_in;
      ry_i = -ry_in;
      rz_i = (zs > 0) ? zs - 34'sd2147483648 : zs + 34'sd2147483648;
    end else begin
      rx_i = rx_in;
      ry_i = ry_in;
      rz_i = zs;
    end
  end

  // Gain removal in two slices: low slice unsigned, high slice signed.
  assign src     = (cmd_i.op == OP_MUL_XL || cmd_i.op == OP_MUL_XH) ? x_q : y_q;
  assign ph      = $signed(src[WorkW-1:MulSplit]) * $signed({1'b0, InvGain});
  assign msum    = (SumW'(ph) <<< MulSplit) + $signed({{(SumW-PloW){1'b0}}, plo_q});
  assign mul_res = WorkW'(msum >>> 30);

  assign mag21 = round21(ux_q);
  assign rx21  = round21(ux_q);
  assign ry21  = round21(uy_q);
  assign ar_w  = WorkW'(ar_q);
  assign ai_w  = WorkW'(ai_q);
  assign lv_w  = $signed({2'b00, lv_q});
  assign lv_n  = (lv_q == '0) ? $signed({2'b00, mag21_q})
                              : lv_w + (($signed({2'b00, mag21_q}) - lv_w) >>> LeakShift);

  // Per-lane result formatting.
  function automatic logic [15:0] soft_fmt(input logic signed [WorkW-1:0] comp,
                                           input logic lv_zero, input logic ovf,
                                           input logic neg, input logic [DivSteps-1:0] qt);
    logic signed [WorkW-1:0] v;
    logic [15:0]             res;
    v = (-comp) >>> (29 - 11);
    if (lv_zero) begin
      if (v > WorkW'(32767))       res = 16'h7FFF;
      else if (v < -WorkW'(32768)) res = 16'h8000;
      else                         res = v[15:0];
    end else if (ovf) begin
      res = neg ? 16'h8000 : 16'h7FFF;
    end else if (neg) begin
      res = (qt > DivSteps'(32768)) ? 16'h8000 : 16'(-qt);
    end else begin
      res = (qt > DivSteps'(32767)) ? 16'h7FFF : qt[15:0];
    end
    return res;
  endfunction

  logic signed [WorkW-1:0] comp [2];
  assign comp[0] = ux_q;
  assign comp[1] = uy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ar_q <= '0;
      ai_q <= '0;
      lv_q <= '0;
    end else if (cmd_i.op == OP_AVG) begin
      ar_q <= 32'(ar_w + ((rx21 - ar_w) >>> LeakShift));
      ai_q <= 32'(ai_w + ((ry21 - ai_w) >>> LeakShift));
      lv_q <= 32'(lv_n);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x0_q  <= 32'(to_work(diff_real_i));
        y0_q  <= 32'(to_work(diff_imag_i));
        tag_q <= sample_tag_i;
        x_q   <= vx_i;
        y_q   <= vy_i;
        z_q   <= vz_i;
      end
      OP_VEC_AVG: begin
        x_q <= vx_i;
        y_q <= vy_i;
        z_q <= vz_i;
      end
      OP_VEC_STEP: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atn;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atn;
        end
      end
      OP_ROT_MAG, OP_ROT_D: begin
        if (cmd_i.op == OP_ROT_MAG) begin
          mag21_q <= 32'(mag21);
        end
        x_q <= rx_i;
        y_q <= ry_i;
        z_q <= rz_i;
      end
      OP_ROT_STEP: begin
        if (z_q >= 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atn;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atn;
        end
      end
      OP_MUL_XL, OP_MUL_YL: plo_q <= src[MulSplit-1:0] * InvGain;
      OP_MUL_XH: ux_q <= mul_res;
      OP_MUL_YH: uy_q <= mul_res;
      OP_DIV_INIT: begin
        d_q <= DivW'(lv_q) << (DivSteps - 1);
        for (int k = 0; k < 2; k++) begin
          logic [DivW-1:0] n;
          n        = DivW'((comp[k] < 0) ? -comp[k] : comp[k]) << 3;
          r_q[k]  <= n;
          qt_q[k] <= '0;
          neg_q[k] <= (comp[k] > 0);
          ovf_q[k] <= ({1'b0, n} >= {lv_q, {DivSteps{1'b0}}});
        end
      end
      OP_DIV_STEP: begin
        d_q <= d_q >> 1;
        for (int k = 0; k < 2; k++) begin
          if (r_q[k] >= d_q) begin
            r_q[k]  <= r_q[k] - d_q;
            qt_q[k] <= {qt_q[k][DivSteps-2:0], 1'b1};
          end else begin
            qt_q[k] <= {qt_q[k][DivSteps-2:0], 1'b0};
          end
        end
      end
      OP_RESULT: begin
        hard_q <= !qpsk_i && (ux_q > 0);
        for (int k = 0; k < 2; k++) begin
          soft_q[k] <= qpsk_i ? soft_fmt(comp[k], lv_q == '0, ovf_q[k], neg_q[k], qt_q[k])
                              : 16'd0;
        end
      end
      default: ;
    endcase
  end

  assign status_o.mag_nz   = (mag21 > 0);
  assign status_o.avg_nz   = (ar_q != '0) || (ai_q != '0);
  assign status_o.level_nz = (lv_q != '0);
  assign status_o.qpsk     = qpsk_i;

  assign hard_bit_o    = hard_q;
  assign soft_first_o  = soft_q[0];
  assign soft_second_o = soft_q[1];
  assign tag_out_o     = tag_q;

endmodule

### rtl/dpsk_demod_fine_afc_top.sv
// ----------------------------------------------------------------------------
// dpsk_demod_fine_afc_top
// DPSK decision stage with power-law fine AFC.
// ----------------------------------------------------------------------------
// One symbol is processed at a time. The single shared CORDIC makes four
// passes at one micro-rotation per cycle: vectoring the phasor, rotating the
// raised term, vectoring the average and rotating the phasor back. A gain
// multiply of the x component (low and high slice) follows the first pass
// and one of both components follows each rotation. In QPSK with a nonzero
// level a serial divider (a load step and 17 quotient bits) forms the soft
// values; BPSK skips it. A zero magnitude skips the raised-term pass and a
// zero average skips the average pass. The finished result sits in an output
// register, so the next symbol is accepted while it waits to be taken.
// qpsk_mode should be written only while the block is idle.
module dpsk_demod_fine_afc_top #(
  parameter int SampleBits  = dfa_pkg::SampleBitsDef,
  parameter int CordicSteps = dfa_pkg::CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i,     // qpsk_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // diff_real[15:0], diff_imag[31:16], sample_tag[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // hard_bit[0], soft_first[16:1], soft_second[32:17],
                                      // tag_out[64:33], zero[71:65]
);
  import dfa_pkg::*;

  logic       mode_q;
  logic       out_valid_q;
  logic [64:0] out_data_q;
  logic       out_free;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       hard_bit;
  logic [15:0] soft_first, soft_second;
  logic [31:0] tag_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i[0];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  dfa_ctrl #(
    .CordicSteps(CordicSteps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfa_datapath #(
    .SampleBits(SampleBits)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .qpsk_i        (mode_q),
    .diff_real_i   (s_axis_tdata[15:0]),
    .diff_imag_i   (s_axis_tdata[31:16]),
    .sample_tag_i  (s_axis_tdata[63:32]),
    .status_o      (status),
    .hard_bit_o    (hard_bit),
    .soft_first_o  (soft_first),
    .soft_second_o (soft_second),
    .tag_out_o     (tag_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.op == OP_OUT_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.op == OP_OUT_LOAD) begin
      out_data_q <= {tag_out, soft_second, soft_first, hard_bit};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q};

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_OUT_LOAD && out_valid_q) |-> m_axis_tready)
    else $error("output register overwritten while a result was pending");

  // Once a symbol is taken, no second one is taken until it is finished.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a symbol is in progress");

  // A result only appears after the sequencer has loaded one.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.op == OP_OUT_LOAD))
    else $error("output valid raised without a result load");

endmodule
